// ----- rtl/core/spsc_pkg.sv -----
// shared types and constants for the screen power state controller
package spsc_pkg;

   localparam int unsigned FIELD_BITS        = 24;
   localparam int unsigned TIMER_BITS_DEFAULT = 24;

   localparam logic [FIELD_BITS-1:0] SLEEP_TIMEOUT_RESET = 24'd3000;
   localparam logic [FIELD_BITS-1:0] DIM_TIMEOUT_RESET   = 24'd0;

   localparam logic [7:0] LEVEL_NORMAL = 8'd200;
   localparam logic [7:0] LEVEL_DIM    = 8'd20;
   localparam logic [7:0] LEVEL_SLEEP  = 8'd0;

   localparam logic [1:0] MODE_CODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_CODE_DIM    = 2'd1;
   localparam logic [1:0] MODE_CODE_SLEEP  = 2'd2;

   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_ACTIVITY = 3'd1;
   localparam logic [2:0] REQ_POWER    = 3'd2;
   localparam logic [2:0] REQ_SLEEP    = 3'd3;
   localparam logic [2:0] REQ_LOCK     = 3'd4;

   localparam logic CSR_DIM_TIMEOUT   = 1'b0;
   localparam logic CSR_SLEEP_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      ST_NORMAL = 3'b001,
      ST_DIM    = 3'b010,
      ST_SLEEP  = 3'b100
   } state_type;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [FIELD_BITS-1:0] activity_ms;
      logic                  key_down;
      logic                  lock_value;
   } spsc_request_type;

   typedef struct packed {
      logic [1:0] power_state;
      logic       screen_on;
      logic [7:0] backlight_level;
      logic       state_changed;
   } spsc_result_type;

   typedef struct packed {
      state_type mode;
      logic      run;
      logic      lock;
   } spsc_ctrl_type;

endpackage

// ----- rtl/core/spsc_next.sv -----
// next-state and result logic for one request
module spsc_next #(
   parameter int unsigned TIMER_BITS = spsc_pkg::TIMER_BITS_DEFAULT
) (
   input  spsc_pkg::spsc_request_type         req,
   input  spsc_pkg::spsc_ctrl_type            ctrl,
   input  logic [TIMER_BITS-1:0]              rem,
   input  logic [spsc_pkg::FIELD_BITS-1:0]    dim_timeout,
   input  logic [spsc_pkg::FIELD_BITS-1:0]    sleep_timeout,
   output spsc_pkg::spsc_ctrl_type            ctrl_next,
   output logic [TIMER_BITS-1:0]              rem_next,
   output spsc_pkg::spsc_result_type          result
);

   localparam int unsigned WIDE =
      (TIMER_BITS > spsc_pkg::FIELD_BITS) ? TIMER_BITS : spsc_pkg::FIELD_BITS;
   localparam logic [WIDE-1:0] TIMER_MAX = WIDE'({TIMER_BITS{1'b1}});

   function automatic logic [TIMER_BITS-1:0] sat_len(
      input logic [spsc_pkg::FIELD_BITS-1:0] len
   );
      logic [WIDE-1:0] len_w;
      len_w = WIDE'(len);
      if (len_w > TIMER_MAX) begin
         sat_len = {TIMER_BITS{1'b1}};
      end else begin
         sat_len = len_w[TIMER_BITS-1:0];
      end
   endfunction

   logic [spsc_pkg::FIELD_BITS-1:0] act_len;
   logic [TIMER_BITS-1:0]           sat_dim;
   logic [TIMER_BITS-1:0]           sat_sleep;
   logic [TIMER_BITS-1:0]           sat_act;
   logic                            dim_on;
   logic                            arm_ok;

   assign act_len   = (req.activity_ms > dim_timeout) ? req.activity_ms : dim_timeout;
   assign sat_dim   = sat_len(dim_timeout);
   assign sat_sleep = sat_len(sleep_timeout);
   assign sat_act   = sat_len(act_len);
   assign dim_on    = (dim_timeout != '0);
   assign arm_ok    = !ctrl.lock && dim_on;

   always_comb begin
      ctrl_next = ctrl;
      rem_next  = rem;
      case (req.req_type)
         spsc_pkg::REQ_TICK: begin
            if (ctrl.run) begin
               if (rem <= TIMER_BITS'(1)) begin
                  ctrl_next.run = 1'b0;
                  rem_next      = '0;
                  if (ctrl.mode == spsc_pkg::ST_NORMAL) begin
                     ctrl_next.mode = spsc_pkg::ST_DIM;
                     ctrl_next.run  = 1'b1;
                     rem_next       = sat_sleep;
                  end else if (ctrl.mode == spsc_pkg::ST_DIM) begin
                     ctrl_next.mode = spsc_pkg::ST_SLEEP;
                  end
               end else begin
                  rem_next = rem - TIMER_BITS'(1);
               end
            end
         end
         spsc_pkg::REQ_ACTIVITY: begin
            if (ctrl.mode != spsc_pkg::ST_SLEEP) begin
               ctrl_next.mode = spsc_pkg::ST_NORMAL;
               if (arm_ok) begin
                  ctrl_next.run = 1'b1;
                  rem_next      = sat_act;
               end else if (ctrl.mode == spsc_pkg::ST_DIM) begin
                  ctrl_next.run = 1'b0;
               end
            end
         end
         spsc_pkg::REQ_POWER: begin
            if (req.key_down) begin
               if (ctrl.mode == spsc_pkg::ST_NORMAL) begin
                  ctrl_next.mode = spsc_pkg::ST_SLEEP;
                  ctrl_next.run  = 1'b0;
               end else begin
                  ctrl_next.mode = spsc_pkg::ST_NORMAL;
                  ctrl_next.run  = arm_ok;
                  if (arm_ok) begin
                     rem_next = sat_dim;
                  end
               end
            end
         end
         spsc_pkg::REQ_SLEEP: begin
            if (!ctrl.lock && ctrl.mode != spsc_pkg::ST_SLEEP) begin
               ctrl_next.mode = spsc_pkg::ST_SLEEP;
               ctrl_next.run  = 1'b0;
            end
         end
         spsc_pkg::REQ_LOCK: begin
            if (req.lock_value != ctrl.lock) begin
               ctrl_next.lock = req.lock_value;
               if (req.lock_value) begin
                  ctrl_next.run  = 1'b0;
                  ctrl_next.mode = spsc_pkg::ST_NORMAL;
               end else if (dim_on) begin
                  ctrl_next.run = 1'b1;
                  rem_next      = sat_dim;
               end
            end
         end
         default: begin
            // unknown request codes leave everything as is
         end
      endcase
   end

   always_comb begin
      result.state_changed = (ctrl_next.mode != ctrl.mode);
      result.screen_on     = (ctrl_next.mode != spsc_pkg::ST_SLEEP);
      case (ctrl_next.mode)
         spsc_pkg::ST_NORMAL: begin
            result.power_state     = spsc_pkg::MODE_CODE_NORMAL;
            result.backlight_level = spsc_pkg::LEVEL_NORMAL;
         end
         spsc_pkg::ST_DIM: begin
            result.power_state     = spsc_pkg::MODE_CODE_DIM;
            result.backlight_level = spsc_pkg::LEVEL_DIM;
         end
         default: begin
            result.power_state     = spsc_pkg::MODE_CODE_SLEEP;
            result.backlight_level = spsc_pkg::LEVEL_SLEEP;
         end
      endcase
   end

endmodule

// ----- rtl/core/screen_power_state_controller.sv -----
// top level of the screen power state controller
//
//   port group | direction | holds
//   req_*      | in        | one event request (spsc_request_type)
//   rsp_*      | out       | one result per request (spsc_result_type)
//   csr_*      | in        | timeout register writes
//
// one request per clock while rsp_stall is low; a taken request passes the input register,
// then the result register, to rsp, and the next state is updated with the result register.
// reset is synchronous: normal state, timer stopped, unlocked, dim timeout 0, sleep 3000.
// rsp_stall holds the result register; the input register then fills and req_stall rises
// only while both registers are full and the result is not being taken.
module screen_power_state_controller #(
   parameter int unsigned TIMER_BITS = spsc_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  spsc_pkg::spsc_request_type      req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output spsc_pkg::spsc_result_type       rsp_data,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [spsc_pkg::FIELD_BITS-1:0] csr_wr_data
);

   logic                            in_valid_ff;
   logic                            in_valid_in;
   spsc_pkg::spsc_request_type      in_data_ff;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   spsc_pkg::spsc_result_type       out_data_ff;
   spsc_pkg::spsc_ctrl_type         ctrl_ff;
   spsc_pkg::spsc_ctrl_type         ctrl_in;
   logic [TIMER_BITS-1:0]           rem_ff;
   logic [TIMER_BITS-1:0]           rem_in;
   logic [spsc_pkg::FIELD_BITS-1:0] dim_timeout_ff;
   logic [spsc_pkg::FIELD_BITS-1:0] sleep_timeout_ff;
   spsc_pkg::spsc_result_type       result;
   logic                            advance;
   logic                            req_take;

   spsc_next #(
      .TIMER_BITS(TIMER_BITS)
   ) u_next (
      .req           (in_data_ff),
      .ctrl          (ctrl_ff),
      .rem           (rem_ff),
      .dim_timeout   (dim_timeout_ff),
      .sleep_timeout (sleep_timeout_ff),
      .ctrl_next     (ctrl_in),
      .rem_next      (rem_in),
      .result        (result)
   );

   // request in the input register moves on when the result register is free
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         ctrl_ff.mode     <= spsc_pkg::ST_NORMAL;
         ctrl_ff.run      <= 1'b0;
         ctrl_ff.lock     <= 1'b0;
         rem_ff           <= '0;
         dim_timeout_ff   <= spsc_pkg::DIM_TIMEOUT_RESET;
         sleep_timeout_ff <= spsc_pkg::SLEEP_TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctrl_ff <= ctrl_in;
            rem_ff  <= rem_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               spsc_pkg::CSR_DIM_TIMEOUT:   dim_timeout_ff   <= csr_wr_data;
               spsc_pkg::CSR_SLEEP_TIMEOUT: sleep_timeout_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

`ifndef SYNTHESIS
   // lock always leaves the dim timer stopped
   a_lock_stops_timer: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.lock |-> !ctrl_ff.run)
      else $error("timer running while locked");

   // dim is only left by timeout, activity, key, sleep request or lock, so its timer runs
   a_dim_timer_runs: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.mode == spsc_pkg::ST_DIM) |-> ctrl_ff.run)
      else $error("dim state without a running timer");

   // a held request reaches an empty result register in the next cycle
   a_request_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("request not moved to result register");
`endif

endmodule

// ----- sim/screen_power_state_controller_tb.sv -----
// self-checking testbench for the screen power state controller
`timescale 1ns / 100ps

module screen_power_state_controller_tb;

   localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned PIPE_SETTLE = 4;
   localparam int unsigned HOLD_CYCLES = 64;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   spsc_pkg::spsc_request_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   spsc_pkg::spsc_result_type rsp_data;
   logic csr_wr_en;
   logic csr_index;
   logic [spsc_pkg::FIELD_BITS-1:0] csr_wr_data;

   // shadow copy of the controller state
   logic [1:0] pred_mode;
   logic [spsc_pkg::FIELD_BITS-1:0] pred_left;
   logic pred_run;
   logic pred_lock;
   logic [spsc_pkg::FIELD_BITS-1:0] dim_ticks;
   logic [spsc_pkg::FIELD_BITS-1:0] sleep_ticks;

   spsc_pkg::spsc_request_type queued_events[$];
   spsc_pkg::spsc_result_type awaited_results[$];
   spsc_pkg::spsc_result_type oldest_result;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned mismatch_count;
   logic request_taken;
   logic hold_off;
   logic pressure_go;

   screen_power_state_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void arm_timer(input logic [spsc_pkg::FIELD_BITS-1:0] len);
      pred_left = len;
      pred_run = 1'b1;
   endfunction

   function automatic void move_to(input logic [1:0] next);
      if (next != pred_mode) begin
         pred_mode = next;
         pred_run = 1'b0;
         if (next == spsc_pkg::MODE_CODE_NORMAL) begin
            if (!pred_lock && dim_ticks != '0) arm_timer(dim_ticks);
         end else if (next == spsc_pkg::MODE_CODE_DIM) begin
            arm_timer(sleep_ticks);
         end
      end
   endfunction

   function automatic spsc_pkg::spsc_result_type screen_response(
      input spsc_pkg::spsc_request_type ev
   );
      logic [1:0] prior;
      spsc_pkg::spsc_result_type res;
      prior = pred_mode;
      case (ev.req_type)
         spsc_pkg::REQ_TICK: begin
            if (pred_run) begin
               if (pred_left <= 24'd1) begin
                  pred_run = 1'b0;
                  pred_left = '0;
                  if (pred_mode == spsc_pkg::MODE_CODE_NORMAL) begin
                     move_to(spsc_pkg::MODE_CODE_DIM);
                  end else if (pred_mode == spsc_pkg::MODE_CODE_DIM) begin
                     move_to(spsc_pkg::MODE_CODE_SLEEP);
                  end
               end else begin
                  pred_left = pred_left - 24'd1;
               end
            end
         end
         spsc_pkg::REQ_ACTIVITY: begin
            if (pred_mode != spsc_pkg::MODE_CODE_SLEEP) begin
               move_to(spsc_pkg::MODE_CODE_NORMAL);
               if (!pred_lock && dim_ticks != '0) begin
                  arm_timer(ev.activity_ms > dim_ticks ? ev.activity_ms : dim_ticks);
               end
            end
         end
         spsc_pkg::REQ_POWER: begin
            if (ev.key_down) begin
               if (pred_mode == spsc_pkg::MODE_CODE_NORMAL) begin
                  move_to(spsc_pkg::MODE_CODE_SLEEP);
               end else begin
                  move_to(spsc_pkg::MODE_CODE_NORMAL);
               end
            end
         end
         spsc_pkg::REQ_SLEEP: begin
            if (!pred_lock) move_to(spsc_pkg::MODE_CODE_SLEEP);
         end
         spsc_pkg::REQ_LOCK: begin
            if (ev.lock_value != pred_lock) begin
               pred_lock = ev.lock_value;
               if (ev.lock_value) begin
                  pred_run = 1'b0;
                  move_to(spsc_pkg::MODE_CODE_NORMAL);
               end else if (dim_ticks != '0) begin
                  arm_timer(dim_ticks);
               end
            end
         end
         default: begin
         end
      endcase
      res.power_state = pred_mode;
      res.screen_on = (pred_mode != spsc_pkg::MODE_CODE_SLEEP);
      if (pred_mode == spsc_pkg::MODE_CODE_NORMAL) begin
         res.backlight_level = spsc_pkg::LEVEL_NORMAL;
      end else if (pred_mode == spsc_pkg::MODE_CODE_DIM) begin
         res.backlight_level = spsc_pkg::LEVEL_DIM;
      end else begin
         res.backlight_level = spsc_pkg::LEVEL_SLEEP;
      end
      res.state_changed = (pred_mode != prior);
      return res;
   endfunction

   // request driver: a presented request holds until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || request_taken) begin
         if (queued_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= queued_events.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // accepted requests feed the predictor, accepted results are checked
   always @(posedge clock) begin
      request_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            request_taken = 1'b1;
            awaited_results.push_back(screen_response(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected result: state %0d on %0d level %0d changed %0d",
                           rsp_data.power_state, rsp_data.screen_on,
                           rsp_data.backlight_level, rsp_data.state_changed);
               end
            end else begin
               oldest_result = awaited_results.pop_front();
               if (rsp_data.power_state !== oldest_result.power_state ||
                   rsp_data.screen_on !== oldest_result.screen_on ||
                   rsp_data.backlight_level !== oldest_result.backlight_level ||
                   rsp_data.state_changed !== oldest_result.state_changed) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("result mismatch at %0t: expected state %0d on %0d level %0d",
                              $realtime, oldest_result.power_state, oldest_result.screen_on,
                              oldest_result.backlight_level);
                     $display("   changed %0d, got state %0d on %0d level %0d changed %0d",
                              oldest_result.state_changed, rsp_data.power_state,
                              rsp_data.screen_on, rsp_data.backlight_level,
                              rsp_data.state_changed);
                  end
               end
            end
         end
      end
   end

   // long receiver hold-off so both pipeline stages fill and the input stalls
   initial begin
      hold_off = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   task automatic push_event(input logic [2:0] kind,
                             input logic [spsc_pkg::FIELD_BITS-1:0] ms,
                             input logic key, input logic lock_req);
      spsc_pkg::spsc_request_type ev;
      ev.req_type = kind;
      ev.activity_ms = ms;
      ev.key_down = key;
      ev.lock_value = lock_req;
      queued_events.push_back(ev);
   endtask

   task automatic push_random_events(input int unsigned count);
      spsc_pkg::spsc_request_type ev;
      logic [31:0] rnd;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         // mostly short stay-awake times so the timeouts still fire
         rnd = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom();
         ev.activity_ms = rnd[spsc_pkg::FIELD_BITS-1:0];
         rnd = $urandom();
         ev.key_down = rnd[0];
         ev.lock_value = rnd[1];
         if (pick < 45) begin
            ev.req_type = spsc_pkg::REQ_TICK;
         end else if (pick < 65) begin
            ev.req_type = spsc_pkg::REQ_ACTIVITY;
         end else if (pick < 77) begin
            ev.req_type = spsc_pkg::REQ_POWER;
         end else if (pick < 85) begin
            ev.req_type = spsc_pkg::REQ_SLEEP;
         end else if (pick < 95) begin
            ev.req_type = spsc_pkg::REQ_LOCK;
         end else begin
            rnd = $urandom_range(2);
            ev.req_type = REQ_UNKNOWN_FIRST + rnd[2:0];
         end
         queued_events.push_back(ev);
      end
   endtask

   task automatic wait_quiet();
      while (queued_events.size() != 0 || req_valid || awaited_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic program_timeouts(input logic [spsc_pkg::FIELD_BITS-1:0] dim_val,
                                   input logic [spsc_pkg::FIELD_BITS-1:0] sleep_val);
      wait_quiet();
      repeat (PIPE_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= spsc_pkg::CSR_DIM_TIMEOUT;
      csr_wr_data <= dim_val;
      @(negedge clock);
      csr_index <= spsc_pkg::CSR_SLEEP_TIMEOUT;
      csr_wr_data <= sleep_val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      dim_ticks = dim_val;
      sleep_ticks = sleep_val;
   endtask

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = spsc_pkg::CSR_DIM_TIMEOUT;
      csr_wr_data = '0;
      request_taken = 1'b0;
      pressure_go = 1'b0;
      mismatch_count = 0;
      send_idle_pct = 11;
      recv_stall_pct = 79;
      pred_mode = spsc_pkg::MODE_CODE_NORMAL;
      pred_left = '0;
      pred_run = 1'b0;
      pred_lock = 1'b0;
      dim_ticks = spsc_pkg::DIM_TIMEOUT_RESET;
      sleep_ticks = spsc_pkg::SLEEP_TIMEOUT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: no dimming until activity with dimming enabled
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_ACTIVITY, 24'd7, 1'b0, 1'b0);
      program_timeouts(24'd2, 24'd1);

      // directed walk through every request kind and corner
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_ACTIVITY, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_ACTIVITY, 24'd5, 1'b1, 1'b1);
      push_event(spsc_pkg::REQ_POWER, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_POWER, '0, 1'b1, 1'b0);
      push_event(spsc_pkg::REQ_POWER, '0, 1'b1, 1'b0);
      push_event(spsc_pkg::REQ_POWER, '0, 1'b1, 1'b0);
      push_event(spsc_pkg::REQ_SLEEP, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_POWER, '0, 1'b1, 1'b0);
      push_event(spsc_pkg::REQ_LOCK, '0, 1'b0, 1'b1);
      push_event(spsc_pkg::REQ_LOCK, '0, 1'b0, 1'b1);
      push_event(spsc_pkg::REQ_SLEEP, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_POWER, '0, 1'b1, 1'b1);
      // unlock while sleeping: the timer runs but its expiry changes nothing
      push_event(spsc_pkg::REQ_LOCK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_TICK, '0, 1'b0, 1'b0);
      push_event(spsc_pkg::REQ_POWER, '0, 1'b1, 1'b0);
      push_event(spsc_pkg::REQ_ACTIVITY, 24'hFFFFFF, 1'b1, 1'b1);
      push_event(REQ_UNKNOWN_FIRST, 24'hFFFFFF, 1'b1, 1'b1);
      push_event(REQ_UNKNOWN_FIRST + 3'd1, 24'hFFFFFF, 1'b1, 1'b1);
      push_event(REQ_UNKNOWN_FIRST + 3'd2, 24'hFFFFFF, 1'b1, 1'b1);
      push_random_events(140);

      program_timeouts('0, 24'hFFFFFF);
      push_random_events(150);

      send_idle_pct = 79;
      recv_stall_pct = 11;
      program_timeouts(24'd5, '0);
      push_random_events(170);
      program_timeouts(24'hFFFFFF, 24'd3);
      push_random_events(150);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      program_timeouts(24'd1, 24'd2);
      push_random_events(160);
      pressure_go = 1'b1;
      program_timeouts(24'd3, 24'd4);
      push_random_events(150);

      wait_quiet();
      repeat (PIPE_SETTLE * 2) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/spsc_pkg.sv
rtl/core/spsc_next.sv
rtl/core/screen_power_state_controller.sv
sim/screen_power_state_controller_tb.sv
